// File: rtl/dupd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dupd_pkg: shared types and constants of the data-URI payload decoder
// Holds character codes, the result word layout, queue sizing and the two
// symbol lookup functions for base64 and hex digits.
// ----------------------------------------------------------------------------
package dupd_pkg;

    // Input character and result widths.
    localparam int CHAR_W      = 16;
    localparam int ASCII_W     = 7;
    localparam int BYTE_W      = 8;
    localparam int SEXTET_W    = 6;
    localparam int NIBBLE_W    = 4;
    localparam int ACC_W       = 3 * SEXTET_W;
    localparam int GROUP_W     = 4 * SEXTET_W;

    // Up to three result words leave one decode step.
    localparam int RESULT_MAX  = 3;
    localparam int RCNT_W      = 2;

    // Result queue sizing.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // Character codes.
    localparam logic [CHAR_W-1:0]  ASCII_MAX    = 16'd127;
    localparam logic [ASCII_W-1:0] CHAR_EQUALS  = 7'h3D;
    localparam logic [ASCII_W-1:0] CHAR_PERCENT = 7'h25;
    localparam logic [ASCII_W-1:0] CHAR_PLUS    = 7'h2B;
    localparam logic [ASCII_W-1:0] CHAR_SLASH   = 7'h2F;
    localparam logic [ASCII_W-1:0] CASE_MASK    = 7'h5F;

    // Escape sequence phases in percent mode.
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    // Payload encodings.
    localparam logic MODE_PERCENT = 1'b0;
    localparam logic MODE_BASE64  = 1'b1;

    // One result word.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              bad_input;
        logic              end_of_message;
    } result_t;

    // Result words produced by one decode step.
    typedef struct packed {
        logic [RCNT_W-1:0]              count;
        result_t [RESULT_MAX-1:0]       res;
    } result_bundle_t;

    // Lookup result: valid flag and value.
    typedef struct packed {
        logic                ok;
        logic [SEXTET_W-1:0] value;
    } sextet_t;

    typedef struct packed {
        logic                ok;
        logic [NIBBLE_W-1:0] value;
    } nibble_t;

    // Base64 symbol value of a 7-bit code.
    function automatic sextet_t sextet_of(input logic [ASCII_W-1:0] c);
        sextet_t r;
        r.ok    = 1'b1;
        r.value = '0;
        if (c >= 7'h41 && c <= 7'h5A) begin
            r.value = SEXTET_W'(c - 7'h41);
        end
        else if (c >= 7'h61 && c <= 7'h7A) begin
            r.value = SEXTET_W'(c - 7'h61 + 7'd26);
        end
        else if (c >= 7'h30 && c <= 7'h39) begin
            r.value = SEXTET_W'(c - 7'h30 + 7'd52);
        end
        else if (c == CHAR_PLUS) begin
            r.value = 6'd62;
        end
        else if (c == CHAR_SLASH) begin
            r.value = 6'd63;
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Hex digit value of a 7-bit code, either case.
    function automatic nibble_t nibble_of(input logic [ASCII_W-1:0] c);
        nibble_t          r;
        logic [ASCII_W-1:0] u;
        u       = c & CASE_MASK;
        r.ok    = 1'b1;
        r.value = '0;
        if (c >= 7'h30 && c <= 7'h39) begin
            r.value = NIBBLE_W'(c - 7'h30);
        end
        else if (u >= 7'h41 && u <= 7'h46) begin
            r.value = NIBBLE_W'(u - 7'h41 + 7'd10);
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/dupd_input_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dupd_input_reg: input word register
// Captures one character word and its end flag; frees itself when the decode
// step consumes the held word.
// ----------------------------------------------------------------------------
module dupd_input_reg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dupd_pkg::CHAR_W-1:0]  char_code,
    input  wire logic                         last_char,
    input  wire logic                         advance,
    output logic                              held_valid,
    output logic [dupd_pkg::CHAR_W-1:0]       held_char,
    output logic                              held_last
);

    logic                        vld_reg;
    logic                        vld_next;
    logic [dupd_pkg::CHAR_W-1:0] char_reg;
    logic                        last_reg;

    // Take a new word when empty or when the held word leaves this cycle.
    assign in_ready = !vld_reg || advance;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    assign held_valid = vld_reg;
    assign held_char  = char_reg;
    assign held_last  = last_reg;

endmodule
`default_nettype wire

// File: rtl/dupd_decode_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dupd_decode_core: message state and single-step decode
// Holds the encoding mode and the per-message state, and turns one held
// character into zero to three result words in one pass of logic.
// ----------------------------------------------------------------------------
module dupd_decode_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,
    input  wire logic                           held_valid,
    input  wire logic [dupd_pkg::CHAR_W-1:0]    held_char,
    input  wire logic                           held_last,
    input  wire logic [dupd_pkg::QUEUE_CW-1:0]  queue_free,
    output logic                                advance,
    output dupd_pkg::result_bundle_t            bundle
);

    logic                            mode_reg;
    logic [dupd_pkg::ACC_W-1:0]      acc_reg,   acc_next;
    logic [1:0]                      cnt_reg,   cnt_next;
    logic [2:0]                      pad_reg,   pad_next;
    dupd_pkg::esc_phase_t            esc_reg,   esc_next;
    logic [dupd_pkg::NIBBLE_W-1:0]   hnib_reg,  hnib_next;
    logic                            err_reg,   err_next;

    logic [dupd_pkg::ASCII_W-1:0]    c7;
    dupd_pkg::sextet_t               sx;
    dupd_pkg::nibble_t               nb;
    logic [dupd_pkg::GROUP_W-1:0]    group_word;

    assign c7         = held_char[dupd_pkg::ASCII_W-1:0];
    assign sx         = dupd_pkg::sextet_of(c7);
    assign nb         = dupd_pkg::nibble_of(c7);
    assign group_word = {acc_reg, sx.value};

    // Decode one character; results are collected into the bundle.
    always_comb
    begin
        logic [dupd_pkg::RCNT_W-1:0] n;
        dupd_pkg::result_t [dupd_pkg::RESULT_MAX-1:0] res;

        n         = '0;
        res       = '0;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        esc_next  = esc_reg;
        hnib_next = hnib_reg;
        err_next  = err_reg;

        if (!err_reg)
        begin
            if (held_char > dupd_pkg::ASCII_MAX)
            begin
                err_next = 1'b1;
            end
            else if (mode_reg == dupd_pkg::MODE_BASE64)
            begin
                if (c7 == dupd_pkg::CHAR_EQUALS)
                begin
                    // Padding only after two symbols, never past four characters.
                    if ((pad_reg == 3'd0 && cnt_reg < 2'd2) ||
                        ({2'b00, cnt_reg} + {1'b0, pad_reg}) >= 4'd4)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        pad_next = pad_reg + 3'd1;
                    end
                end
                else if (!sx.ok || pad_reg != 3'd0)
                begin
                    err_next = 1'b1;
                end
                else if (cnt_reg == 2'd3)
                begin
                    // Fourth symbol completes a group of three bytes.
                    res[0] = '{group_word[23:16], 1'b1, 1'b0, 1'b0};
                    res[1] = '{group_word[15:8],  1'b1, 1'b0, 1'b0};
                    res[2] = '{group_word[7:0],   1'b1, 1'b0, 1'b0};
                    n        = 2'd3;
                    acc_next = '0;
                    cnt_next = 2'd0;
                end
                else
                begin
                    acc_next = {acc_reg[dupd_pkg::ACC_W-dupd_pkg::SEXTET_W-1:0], sx.value};
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            else
            begin
                unique case (esc_reg)
                    dupd_pkg::ESC_NONE:
                    begin
                        if (c7 == dupd_pkg::CHAR_PERCENT)
                        begin
                            esc_next = dupd_pkg::ESC_HIGH;
                        end
                        else
                        begin
                            res[0] = '{held_char[dupd_pkg::BYTE_W-1:0], 1'b1, 1'b0, 1'b0};
                            n      = 2'd1;
                        end
                    end
                    dupd_pkg::ESC_HIGH:
                    begin
                        if (!nb.ok)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            hnib_next = nb.value;
                            esc_next  = dupd_pkg::ESC_LOW;
                        end
                    end
                    dupd_pkg::ESC_LOW:
                    begin
                        if (!nb.ok)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            res[0]   = '{{hnib_reg, nb.value}, 1'b1, 1'b0, 1'b0};
                            n        = 2'd1;
                            esc_next = dupd_pkg::ESC_NONE;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end

        // End of message: flush a short base64 group or check the escape.
        if (held_last && !err_next)
        begin
            if (mode_reg == dupd_pkg::MODE_BASE64)
            begin
                if (cnt_next == 2'd2)
                begin
                    res[n] = '{acc_next[11:4], 1'b1, 1'b0, 1'b0};
                    n      = n + 2'd1;
                end
                else if (cnt_next == 2'd3)
                begin
                    res[0] = '{acc_next[17:10], 1'b1, 1'b0, 1'b0};
                    res[1] = '{acc_next[9:2],   1'b1, 1'b0, 1'b0};
                    n      = 2'd2;
                end
                else if (cnt_next != 2'd0 || pad_next != 3'd0)
                begin
                    err_next = 1'b1;
                end
            end
            else if (esc_next != dupd_pkg::ESC_NONE)
            begin
                err_next = 1'b1;
            end
        end

        if (held_last)
        begin
            // The ending word carries the error flag or marks the last byte.
            if (err_next)
            begin
                res    = '0;
                res[0] = '{8'd0, 1'b0, 1'b1, 1'b1};
                n      = 2'd1;
            end
            else if (n == 2'd0)
            begin
                res[0] = '{8'd0, 1'b0, 1'b0, 1'b1};
                n      = 2'd1;
            end
            else
            begin
                res[n - 2'd1].end_of_message = 1'b1;
            end
            acc_next  = '0;
            cnt_next  = 2'd0;
            pad_next  = 3'd0;
            esc_next  = dupd_pkg::ESC_NONE;
            hnib_next = '0;
            err_next  = 1'b0;
        end
        else if (err_next)
        begin
            n = 2'd0;
        end

        bundle.count = n;
        bundle.res   = res;
    end

    // The step completes only when the queue has room for all its words.
    assign advance = held_valid &&
                     ({1'b0, bundle.count} <= queue_free);

    // Mode register and message state; a mode write starts a new message.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dupd_pkg::MODE_PERCENT;
            acc_reg  <= '0;
            cnt_reg  <= 2'd0;
            pad_reg  <= 3'd0;
            esc_reg  <= dupd_pkg::ESC_NONE;
            hnib_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
            acc_reg  <= '0;
            cnt_reg  <= 2'd0;
            pad_reg  <= 3'd0;
            esc_reg  <= dupd_pkg::ESC_NONE;
            hnib_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            pad_reg  <= pad_next;
            esc_reg  <= esc_next;
            hnib_reg <= hnib_next;
            err_reg  <= err_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dupd_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dupd_result_queue: result word queue
// Four-entry queue that takes up to three words in a cycle and hands one
// word per cycle to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module dupd_result_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire dupd_pkg::result_bundle_t       bundle,
    output logic [dupd_pkg::QUEUE_CW-1:0]       queue_free,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [dupd_pkg::BYTE_W-1:0]         out_byte,
    output logic                                byte_valid,
    output logic                                bad_input,
    output logic                                end_of_message
);

    dupd_pkg::result_t                 q_reg [dupd_pkg::QUEUE_DEPTH];
    logic [dupd_pkg::QUEUE_AW-1:0]     wr_reg, wr_next;
    logic [dupd_pkg::QUEUE_AW-1:0]     rd_reg, rd_next;
    logic [dupd_pkg::QUEUE_CW-1:0]     cnt_reg, cnt_next;
    logic [dupd_pkg::QUEUE_CW-1:0]     push_cnt;
    logic                              pop;
    dupd_pkg::result_t                 head;

    assign push_cnt   = push ? {1'b0, bundle.count} : '0;
    assign pop        = out_valid && out_ready;
    assign queue_free = dupd_pkg::QUEUE_CW'(dupd_pkg::QUEUE_DEPTH) - cnt_reg;

    // Pointer and fill level update.
    always_comb
    begin
        wr_next  = wr_reg + push_cnt[dupd_pkg::QUEUE_AW-1:0];
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + push_cnt - {{(dupd_pkg::QUEUE_CW-1){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the step's words at consecutive slots.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < dupd_pkg::RESULT_MAX; i++)
        begin
            if (dupd_pkg::QUEUE_CW'(i) < push_cnt)
            begin
                q_reg[wr_reg + dupd_pkg::QUEUE_AW'(i)] <= bundle.res[i];
            end
        end
    end

    // Head word drives the output channel.
    assign head           = q_reg[rd_reg];
    assign out_valid      = (cnt_reg != '0);
    assign out_byte       = head.out_byte;
    assign byte_valid     = head.byte_valid;
    assign bad_input      = head.bad_input;
    assign end_of_message = head.end_of_message;

endmodule
`default_nettype wire

// File: rtl/data_uri_payload_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// data_uri_payload_decoder_unit: data-URI payload decoder
// Decodes a percent-encoded or base64 payload one character word at a time
// and delivers decoded bytes, with an error flag on the ending word.
//
//  Channel   Handshake            Words carried
//  input     in_valid/in_ready    char_code, last_char
//  output    out_valid/out_ready  out_byte, byte_valid, bad_input, end_of_message
//  config    cfg_we               cfg_wdata (encoding mode, 1 base64)
//
// One character word is accepted per cycle while the queue has room; its results
// enter the queue from the input register through one decode pass.
// A base64 group yields three bytes in one step; the four-entry result queue
// drains one word per cycle while out_ready is high; without room it holds input.
// Reset clears the mode to percent decoding and all message state at once.
// ----------------------------------------------------------------------------
module data_uri_payload_decoder_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dupd_pkg::CHAR_W-1:0]   char_code,
    input  wire logic                          last_char,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [dupd_pkg::BYTE_W-1:0]        out_byte,
    output logic                               byte_valid,
    output logic                               bad_input,
    output logic                               end_of_message
);

    logic                           held_valid;
    logic [dupd_pkg::CHAR_W-1:0]    held_char;
    logic                           held_last;
    logic                           advance;
    logic [dupd_pkg::QUEUE_CW-1:0]  queue_free;
    dupd_pkg::result_bundle_t       bundle;

    // Input word register.
    dupd_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .advance    (advance),
        .held_valid (held_valid),
        .held_char  (held_char),
        .held_last  (held_last)
    );

    // Decode step and message state.
    dupd_decode_core u_decode_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .held_valid (held_valid),
        .held_char  (held_char),
        .held_last  (held_last),
        .queue_free (queue_free),
        .advance    (advance),
        .bundle     (bundle)
    );

    // Result queue feeding the output channel.
    dupd_result_queue u_result_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (advance),
        .bundle         (bundle),
        .queue_free     (queue_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .bad_input      (bad_input),
        .end_of_message (end_of_message)
    );

endmodule
`default_nettype wire

// File: tb/data_uri_payload_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// data_uri_payload_decoder_unit_tb: self-checking bench for the payload decoder
// Feeds percent-encoded and base64 payloads one character word at a time,
// predicts every result word from an internal decoder model and compares the
// words that leave the block in order, under changing flow-control pressure.
// ----------------------------------------------------------------------------
module data_uri_payload_decoder_unit_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_NS      = 5_000_000;
    localparam int RANDOM_CHARS  = 28;

    // Ways a generated payload gets damaged.
    typedef enum int {
        NOISE_ASCII,
        NOISE_WIDE,
        NOISE_PAD,
        NOISE_ESCAPE,
        NOISE_DROP
    } noise_kind_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic                          cfg_wdata;
    logic                          in_valid;
    logic                          in_ready;
    logic [dupd_pkg::CHAR_W-1:0]   char_code;
    logic                          last_char;
    logic                          out_valid;
    logic                          out_ready;
    logic [dupd_pkg::BYTE_W-1:0]   out_byte;
    logic                          byte_valid;
    logic                          bad_input;
    logic                          end_of_message;

    // Flow-control settings, in percent of cycles spent idle.
    int                            send_idle_pct;
    int                            recv_idle_pct;
    int                            chars_sent;
    int                            mismatch_count;

    // Decoder model state.
    logic                          mode_q;
    logic [dupd_pkg::ACC_W-1:0]    sextet_acc;
    logic [1:0]                    group_count;
    logic [2:0]                    pad_count;
    dupd_pkg::esc_phase_t          esc_state;
    logic [dupd_pkg::NIBBLE_W-1:0] high_digit;
    logic                          msg_bad;

    dupd_pkg::result_t             pending_words[$];
    dupd_pkg::result_t             want_word;
    logic [dupd_pkg::CHAR_W-1:0]   msg_chars[$];

    data_uri_payload_decoder_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_code      (char_code),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .bad_input      (bad_input),
        .end_of_message (end_of_message)
    );

    always #5 clk = ~clk;

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Base64 alphabet value of a code, or -1 outside the alphabet.
    function automatic int b64_value(input logic [dupd_pkg::CHAR_W-1:0] c);
        if (c >= "A" && c <= "Z") return int'(c) - int'("A");
        if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
        if (c == dupd_pkg::CHAR_PLUS) return 62;
        if (c == dupd_pkg::CHAR_SLASH) return 63;
        return -1;
    endfunction

    // Hex digit value of a code in either case, or -1.
    function automatic int hex_value(input logic [dupd_pkg::CHAR_W-1:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic logic [dupd_pkg::CHAR_W-1:0] b64_symbol(input int idx);
        logic [dupd_pkg::CHAR_W-1:0] r;
        if (idx < 26) r = dupd_pkg::CHAR_W'(int'("A") + idx);
        else if (idx < 52) r = dupd_pkg::CHAR_W'(int'("a") + idx - 26);
        else if (idx < 62) r = dupd_pkg::CHAR_W'(int'("0") + idx - 52);
        else if (idx == 62) r = dupd_pkg::CHAR_W'(dupd_pkg::CHAR_PLUS);
        else r = dupd_pkg::CHAR_W'(dupd_pkg::CHAR_SLASH);
        return r;
    endfunction

    function automatic logic [dupd_pkg::CHAR_W-1:0] hex_symbol(input int v, input logic lower);
        logic [dupd_pkg::CHAR_W-1:0] r;
        if (v < 10) r = dupd_pkg::CHAR_W'(int'("0") + v);
        else if (lower) r = dupd_pkg::CHAR_W'(int'("a") + v - 10);
        else r = dupd_pkg::CHAR_W'(int'("A") + v - 10);
        return r;
    endfunction

    function automatic dupd_pkg::result_t byte_word(input logic [dupd_pkg::BYTE_W-1:0] b);
        dupd_pkg::result_t w;
        w = '0;
        w.out_byte   = b;
        w.byte_valid = 1'b1;
        return w;
    endfunction

    task automatic clear_message_state();
        sextet_acc  = '0;
        group_count = '0;
        pad_count   = '0;
        esc_state   = dupd_pkg::ESC_NONE;
        high_digit  = '0;
        msg_bad     = 1'b0;
    endtask

    // Decode one accepted character and queue the words it should produce.
    task automatic decode_char(input logic [dupd_pkg::CHAR_W-1:0] c, input logic is_last);
        dupd_pkg::result_t            words[$];
        dupd_pkg::result_t            w;
        int                           v;
        logic [dupd_pkg::GROUP_W-1:0] grp;
        if (!msg_bad)
        begin
            if (c > dupd_pkg::ASCII_MAX)
            begin
                msg_bad = 1'b1;
            end
            else if (mode_q == dupd_pkg::MODE_BASE64)
            begin
                if (c == dupd_pkg::CHAR_EQUALS)
                begin
                    // Padding needs two symbols first and may not overfill the group.
                    if ((pad_count == 0 && group_count < 2) || (group_count + pad_count >= 4))
                        msg_bad = 1'b1;
                    else
                        pad_count++;
                end
                else
                begin
                    v = b64_value(c);
                    if (v < 0 || pad_count != 0)
                    begin
                        msg_bad = 1'b1;
                    end
                    else if (group_count == 3)
                    begin
                        grp = {sextet_acc, v[5:0]};
                        words.push_back(byte_word(grp[23:16]));
                        words.push_back(byte_word(grp[15:8]));
                        words.push_back(byte_word(grp[7:0]));
                        sextet_acc  = '0;
                        group_count = '0;
                    end
                    else
                    begin
                        sextet_acc = {sextet_acc[11:0], v[5:0]};
                        group_count++;
                    end
                end
            end
            else if (esc_state == dupd_pkg::ESC_NONE)
            begin
                if (c == dupd_pkg::CHAR_PERCENT)
                    esc_state = dupd_pkg::ESC_HIGH;
                else
                    words.push_back(byte_word(c[7:0]));
            end
            else
            begin
                v = hex_value(c);
                if (v < 0)
                begin
                    msg_bad = 1'b1;
                end
                else if (esc_state == dupd_pkg::ESC_HIGH)
                begin
                    high_digit = v[3:0];
                    esc_state  = dupd_pkg::ESC_LOW;
                end
                else
                begin
                    words.push_back(byte_word({high_digit, v[3:0]}));
                    esc_state = dupd_pkg::ESC_NONE;
                end
            end
        end

        // A short base64 group or an open escape is settled by the final character.
        if (is_last && !msg_bad)
        begin
            if (mode_q == dupd_pkg::MODE_BASE64)
            begin
                if (group_count == 2)
                begin
                    words.push_back(byte_word(sextet_acc[11:4]));
                end
                else if (group_count == 3)
                begin
                    words.push_back(byte_word(sextet_acc[17:10]));
                    words.push_back(byte_word(sextet_acc[9:2]));
                end
                else if (group_count != 0 || pad_count != 0)
                begin
                    msg_bad = 1'b1;
                end
            end
            else if (esc_state != dupd_pkg::ESC_NONE)
            begin
                msg_bad = 1'b1;
            end
        end

        if (is_last)
        begin
            if (msg_bad)
            begin
                words.delete();
                w = '0;
                w.bad_input      = 1'b1;
                w.end_of_message = 1'b1;
                words.push_back(w);
            end
            else if (words.size() == 0)
            begin
                w = '0;
                w.end_of_message = 1'b1;
                words.push_back(w);
            end
            else
            begin
                words[words.size()-1].end_of_message = 1'b1;
            end
            clear_message_state();
        end
        else if (msg_bad)
        begin
            words.delete();
        end

        foreach (words[i]) pending_words.push_back(words[i]);
    endtask

    // Offer one character word, hold it until accepted, then predict its results.
    task automatic send_char(input logic [dupd_pkg::CHAR_W-1:0] code, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= code;
        last_char <= is_last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        decode_char(code, is_last);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic ends);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_char(dupd_pkg::CHAR_W'(s[i]), ends && (i == s.len() - 1));
        end
    endtask

    task automatic send_message(input logic ends);
        foreach (msg_chars[i])
        begin
            send_char(msg_chars[i], ends && (i == msg_chars.size() - 1));
        end
    endtask

    // Stop offering words until every predicted word has come out.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
    endtask

    // Mode writes happen only with the block idle; they also restart the message.
    task automatic write_mode(input logic m);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_q = m;
        clear_message_state();
    endtask

    // Well-formed base64: whole groups and an optional short group, maybe padded.
    task automatic build_base64_message();
        int n_groups;
        int tail;
        msg_chars.delete();
        n_groups = int'($urandom_range(0, 3));
        tail     = int'($urandom_range(0, 2));
        if (n_groups == 0 && tail == 0) tail = 1;
        repeat (n_groups * 4) msg_chars.push_back(b64_symbol(int'($urandom_range(0, 63))));
        if (tail != 0)
        begin
            repeat (tail + 1) msg_chars.push_back(b64_symbol(int'($urandom_range(0, 63))));
            repeat ($urandom_range(0, 3 - tail))
                msg_chars.push_back(dupd_pkg::CHAR_W'(dupd_pkg::CHAR_EQUALS));
        end
    endtask

    // Well-formed percent text: plain characters mixed with escapes.
    task automatic build_percent_message();
        logic [dupd_pkg::CHAR_W-1:0] c;
        msg_chars.delete();
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                msg_chars.push_back(dupd_pkg::CHAR_W'(dupd_pkg::CHAR_PERCENT));
                msg_chars.push_back(hex_symbol(int'($urandom_range(0, 15)),
                                               $urandom_range(0, 1) == 1));
                msg_chars.push_back(hex_symbol(int'($urandom_range(0, 15)),
                                               $urandom_range(0, 1) == 1));
            end
            else
            begin
                do c = dupd_pkg::CHAR_W'($urandom_range(0, 127));
                while (c == dupd_pkg::CHAR_PERCENT);
                msg_chars.push_back(c);
            end
        end
    endtask

    task automatic corrupt_message();
        int          pos;
        noise_kind_t kind;
        pos  = int'($urandom_range(0, msg_chars.size() - 1));
        kind = noise_kind_t'($urandom_range(0, 4));
        case (kind)
            NOISE_ASCII:  msg_chars[pos] = dupd_pkg::CHAR_W'($urandom_range(0, 127));
            NOISE_WIDE:   msg_chars[pos] = dupd_pkg::CHAR_W'($urandom_range(0, 65535));
            NOISE_PAD:    msg_chars[pos] = dupd_pkg::CHAR_W'(dupd_pkg::CHAR_EQUALS);
            NOISE_ESCAPE: msg_chars[pos] = dupd_pkg::CHAR_W'(dupd_pkg::CHAR_PERCENT);
            default:
            begin
                if (msg_chars.size() > 1) msg_chars.delete(pos);
            end
        endcase
    endtask

    task automatic run_random_messages(input int budget);
        int start_count;
        start_count = chars_sent;
        while (chars_sent - start_count < budget)
        begin
            if (mode_q == dupd_pkg::MODE_BASE64)
                build_base64_message();
            else
                build_percent_message();
            if ($urandom_range(0, 4) == 0) corrupt_message();
            // Now and then a payload runs on into the next one without an end mark.
            send_message($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 19) == 0) pause_until_drained();
        end
    endtask

    task automatic test_percent_basics();
        send_char(16'h0000, 1'b0);
        send_char(16'h007F, 1'b0);
        send_text("%aF", 1'b1);
    endtask

    task automatic test_percent_errors();
        send_text("%G1", 1'b1);
        send_char(16'hFFFF, 1'b1);
        send_text("%4", 1'b1);
    endtask

    task automatic test_base64_groups();
        write_mode(dupd_pkg::MODE_BASE64);
        send_text("//+ATQ==", 1'b1);
        send_text("TWE", 1'b1);
    endtask

    task automatic test_base64_errors();
        send_text("=", 1'b1);
        send_text("TQ=Q", 1'b1);
        send_text("TWE==", 1'b1);
        send_text("T", 1'b1);
        send_text("*", 1'b1);
    endtask

    // A mode write in the middle of a payload drops what was pending.
    task automatic test_mode_write_restart();
        write_mode(dupd_pkg::MODE_PERCENT);
        send_text("%4", 1'b0);
        write_mode(dupd_pkg::MODE_BASE64);
        send_text("TW", 1'b0);
        write_mode(dupd_pkg::MODE_BASE64);
        send_text("QUJD", 1'b1);
        write_mode(dupd_pkg::MODE_PERCENT);
        send_text("ok", 1'b1);
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 70;
                end
                1:
                begin
                    send_idle_pct = 70;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_mode(dupd_pkg::MODE_PERCENT);
            run_random_messages(RANDOM_CHARS);
            write_mode(dupd_pkg::MODE_BASE64);
            run_random_messages(RANDOM_CHARS);
        end
    endtask

    // Receiver side: random back-pressure on the result channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare every accepted result word with the oldest predicted word.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                report_mismatch("result word arrived with nothing predicted");
            end
            else
            begin
                want_word = pending_words.pop_front();
                if (out_byte !== want_word.out_byte)
                    report_mismatch($sformatf("out_byte %h, predicted %h",
                                              out_byte, want_word.out_byte));
                if (byte_valid !== want_word.byte_valid)
                    report_mismatch($sformatf("byte_valid %b, predicted %b",
                                              byte_valid, want_word.byte_valid));
                if (bad_input !== want_word.bad_input)
                    report_mismatch($sformatf("bad_input %b, predicted %b",
                                              bad_input, want_word.bad_input));
                if (end_of_message !== want_word.end_of_message)
                    report_mismatch($sformatf("end_of_message %b, predicted %b",
                                              end_of_message, want_word.end_of_message));
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= 1'b0;
        in_valid       <= 1'b0;
        char_code      <= '0;
        last_char      <= 1'b0;
        out_ready      <= 1'b0;
        send_idle_pct  = 7;
        recv_idle_pct  = 70;
        chars_sent     = 0;
        mismatch_count = 0;
        mode_q         = dupd_pkg::MODE_PERCENT;
        clear_message_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_percent_basics();
        test_percent_errors();
        test_base64_groups();
        test_base64_errors();
        test_mode_write_restart();
        test_random_traffic();

        // Let the last words drain, then watch for stray ones.
        pause_until_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/dupd_pkg.sv
rtl/dupd_input_reg.sv
rtl/dupd_decode_core.sv
rtl/dupd_result_queue.sv
rtl/data_uri_payload_decoder_unit.sv
tb/data_uri_payload_decoder_unit_tb.sv
